>>> src/nbc_pkg.sv
package nbc_pkg;

  localparam int DEF_ROUNDS = 10;
  localparam int NUM_RC     = 10;
  localparam int BLK_W      = 128;
  localparam int CFG_IDX_W  = 2;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 2'd1;

  typedef logic [2:0] tap3_t;
  typedef logic [3:0] tap4_t;

  localparam logic [7:0] RC_TAB [NUM_RC] = '{
    8'hC0, 8'h24, 8'h3B, 8'h41, 8'h6D, 8'h4D, 8'hC3, 8'hB7, 8'hD7, 8'h45
  };

  localparam tap4_t SCHED_TAPS [8][4] = '{
    '{4'd1, 4'd3, 4'd8, 4'd9},    '{4'd1, 4'd4, 4'd8, 4'd9},
    '{4'd1, 4'd5, 4'd8, 4'd9},    '{4'd1, 4'd6, 4'd8, 4'd9},
    '{4'd15, 4'd10, 4'd7, 4'd8},  '{4'd15, 4'd11, 4'd7, 4'd8},
    '{4'd15, 4'd12, 4'd7, 4'd8},  '{4'd15, 4'd13, 4'd7, 4'd8}
  };

  localparam tap3_t ROW_TAPS [4][4] = '{
    '{3'd0, 3'd6, 3'd3, 3'd4}, '{3'd0, 3'd5, 3'd3, 3'd4},
    '{3'd0, 3'd3, 3'd4, 3'd5}, '{3'd0, 3'd2, 3'd4, 3'd5}
  };

  typedef struct packed {
    logic        cmd;
    logic [63:0] block_high;
    logic [63:0] block_low;
  } in_t;

  typedef struct packed {
    logic [63:0] out_high;
    logic [63:0] out_low;
  } out_t;

  function automatic logic nl8(input logic [7:0] x, input tap3_t t [4]);
    return x[t[0]] ^ x[t[1]] ^ (x[t[2]] & x[t[3]]);
  endfunction

  function automatic logic nl16(input logic [15:0] x, input tap4_t t [4]);
    return x[t[0]] ^ x[t[1]] ^ (x[t[2]] & x[t[3]]);
  endfunction

  // eight steps of the row register, forward or inverse
  function automatic logic [31:0] row8(input logic [31:0] w, input logic dec);
    logic [7:0] r [4];
    logic       g [4];
    logic       b [4];
    for (int i = 0; i < 4; i++) r[i] = w[31-8*i -: 8];
    for (int n = 0; n < 8; n++) begin
      for (int i = 0; i < 4; i++) g[i] = nl8(r[i], ROW_TAPS[i]);
      if (dec) begin
        b[0] = g[0] ^ g[2] ^ g[3];
        b[1] = g[0] ^ g[1] ^ g[3];
        b[2] = g[0] ^ g[1] ^ g[2];
        b[3] = g[2] ^ g[1] ^ g[3];
      end else begin
        b[0] = g[0] ^ r[2][0] ^ r[3][0];
        b[1] = g[1] ^ r[0][0] ^ r[3][0];
        b[2] = g[2] ^ r[0][0] ^ r[1][0];
        b[3] = g[3] ^ r[2][0] ^ r[1][0];
      end
      for (int i = 0; i < 4; i++) r[i] = {b[i], r[i][7:1]};
    end
    return {r[0], r[1], r[2], r[3]};
  endfunction

  // eight steps of the key register over the eight byte pairs
  function automatic logic [127:0] key8(input logic [127:0] v);
    logic [127:0] x;
    logic [127:0] y;
    logic [7:0]   a;
    logic [7:0]   b;
    logic         carry;
    logic         fb;
    x = v;
    for (int n = 0; n < 8; n++) begin
      y = x;
      for (int j = 0; j < 8; j++) begin
        a     = x[127-16*j -: 8];
        b     = x[119-16*j -: 8];
        carry = (j == 0) ? x[0] : x[128-16*j];
        fb    = carry ^ nl16(x[127-16*j -: 16], SCHED_TAPS[j]);
        y[127-16*j -: 8] = {fb, a[7:1]};
        y[119-16*j -: 8] = {a[0], b[7:1]};
      end
      x = y;
    end
    return x;
  endfunction

  function automatic logic [127:0] flip128(input logic [127:0] x);
    logic [127:0] o;
    for (int i = 0; i < 128; i++) o[i] = x[127-i];
    return o;
  endfunction

  function automatic logic [127:0] transpose(input logic [127:0] x);
    logic [127:0] o;
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4; j++)
        o[127-8*(4*i+j) -: 8] = x[127-8*(4*j+i) -: 8];
    return o;
  endfunction

endpackage

>>> src/nfsr_block_cipher_128.sv
// 128-bit NFSR block cipher, encrypt or decrypt per block under a key held in
// two configuration registers. Blocks stream through 4*ROUNDS register stages
// (one quarter round, eight register steps on each row, per stage), so one
// block per cycle is accepted while in_stall is low; results leave the
// last stage in the order the blocks came in. The round keys are kept in
// registers and are rebuilt by an iterative schedule unit after reset and
// after every key write, half a round per cycle, and in_stall is held high
// while it runs. Write the key only while no block is in flight.
module nfsr_block_cipher_128 #(
  parameter int ROUNDS = nbc_pkg::DEF_ROUNDS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  nbc_pkg::in_t                   in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output nbc_pkg::out_t                  out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [nbc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [63:0]                    cfg_data
);

  localparam int NS = 4 * ROUNDS;
  localparam int KW = $clog2(ROUNDS + 1);

  typedef enum logic [2:0] {
    KS_IDLE = 3'b001,
    KS_LOAD = 3'b010,
    KS_RUN  = 3'b100
  } ks_state_t;

  ks_state_t     ks_state_r, ks_state_nxt;
  logic [63:0]   key_high_r, key_low_r;
  logic [127:0]  kreg_r, kreg_nxt;
  logic [KW-1:0] kr_r, kr_nxt;
  logic [3:0]    rci_r, rci_nxt;
  logic          half_r, half_nxt;
  logic [127:0]  rk_r [1:ROUNDS];
  logic [127:0]  rk_full [0:ROUNDS];
  logic          rk_we;
  logic          cfg_wr;

  logic          v_r   [NS];
  logic          dec_r [NS];
  logic [127:0]  d_r   [NS];
  logic [NS:0]   adv;
  logic          ks_busy;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign ks_busy   = (ks_state_r != KS_IDLE);

  // key registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_high_r <= '0;
      key_low_r  <= '0;
    end else if (cfg_wr) begin
      case (cfg_index)
        nbc_pkg::REG_KEY_HIGH: key_high_r <= cfg_data;
        nbc_pkg::REG_KEY_LOW:  key_low_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // schedule sequencer: half a round per cycle
  always_comb begin
    ks_state_nxt = ks_state_r;
    kreg_nxt     = kreg_r;
    kr_nxt       = kr_r;
    rci_nxt      = rci_r;
    half_nxt     = half_r;
    rk_we        = 1'b0;
    case (ks_state_r)
      KS_IDLE: ;
      KS_LOAD: begin
        kreg_nxt     = {key_high_r, key_low_r};
        kr_nxt       = KW'(1);
        rci_nxt      = '0;
        half_nxt     = 1'b0;
        ks_state_nxt = KS_RUN;
      end
      KS_RUN: begin
        if (!half_r) begin
          kreg_nxt = nbc_pkg::key8(kreg_r ^ {nbc_pkg::RC_TAB[rci_r], 120'd0});
          half_nxt = 1'b1;
        end else begin
          kreg_nxt = nbc_pkg::key8(kreg_r);
          rk_we    = 1'b1;
          half_nxt = 1'b0;
          if (kr_r == KW'(ROUNDS)) begin
            ks_state_nxt = KS_IDLE;
          end else begin
            kr_nxt  = kr_r + KW'(1);
            rci_nxt = (rci_r == 4'(nbc_pkg::NUM_RC - 1)) ? 4'd0 : rci_r + 4'd1;
          end
        end
      end
      default: ks_state_nxt = KS_LOAD;
    endcase
    if (cfg_wr) ks_state_nxt = KS_LOAD;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ks_state_r <= KS_LOAD;
      kr_r       <= KW'(1);
      rci_r      <= '0;
      half_r     <= 1'b0;
    end else begin
      ks_state_r <= ks_state_nxt;
      kr_r       <= kr_nxt;
      rci_r      <= rci_nxt;
      half_r     <= half_nxt;
    end
  end

  // schedule payload, no reset
  always_ff @(posedge clk) begin
    kreg_r <= kreg_nxt;
    if (rk_we) rk_r[kr_r] <= kreg_nxt;
  end

  assign rk_full[0] = {key_high_r, key_low_r};
  for (genvar i = 1; i <= ROUNDS; i++) begin : g_rk
    assign rk_full[i] = rk_r[i];
  end

  // advance: a stage moves when it is empty or its successor moves
  assign adv[NS] = !out_stall || !v_r[NS-1];
  for (genvar s = NS - 1; s >= 0; s--) begin : g_adv
    assign adv[s] = !v_r[s] || adv[s+1];
  end

  // hold input off while keys are rebuilt, a key is written or the first stage cannot advance
  assign in_stall = ks_busy || cfg_valid || !adv[0];

  for (genvar s = 0; s < NS; s++) begin : g_stage
    localparam int R  = s / 4;
    localparam int P  = s % 4;
    localparam int DK = ROUNDS - R;

    logic [127:0] src;
    logic         v_in;
    logic         dec_in;
    logic [127:0] x;
    logic [127:0] y;
    logic [127:0] kenc;
    logic [127:0] kdec;

    if (s == 0) begin : g_src_in
      assign src    = {in_data.block_high, in_data.block_low};
      assign v_in   = in_valid && !ks_busy && !cfg_valid;
      assign dec_in = in_data.cmd;
    end else begin : g_src_prev
      assign src    = d_r[s-1];
      assign v_in   = v_r[s-1];
      assign dec_in = dec_r[s-1];
    end

    // round key for the opening mix of this round
    assign kenc = rk_full[R];
    if (DK == 0 || DK == ROUNDS) begin : g_kd_end
      assign kdec = nbc_pkg::flip128(rk_full[DK]);
    end else begin : g_kd_mid
      assign kdec = nbc_pkg::transpose(nbc_pkg::flip128(rk_full[DK]));
    end

    always_comb begin
      x = src;
      if (P == 0) x = x ^ (dec_in ? kdec : kenc);
      for (int b = 0; b < 4; b++) y[127-32*b -: 32] = nbc_pkg::row8(x[127-32*b -: 32], dec_in);
      if (P == 3) begin
        if (R < ROUNDS - 1) begin
          y = nbc_pkg::transpose(y);
        end else begin
          y = nbc_pkg::flip128(y ^ (dec_in ? nbc_pkg::flip128(rk_full[0])
                                           : rk_full[ROUNDS]));
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (adv[s]) begin
        v_r[s] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv[s]) begin
        d_r[s]   <= y;
        dec_r[s] <= dec_in;
      end
    end
  end

  assign out_valid         = v_r[NS-1];
  assign out_data.out_high = d_r[NS-1][127:64];
  assign out_data.out_low  = d_r[NS-1][63:0];

  // checks
  a_cfg_reload: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr |=> ks_state_r == KS_LOAD)
    else $error("key write did not restart the schedule");

  a_ks_done: assert property (@(posedge clk) disable iff (!rst_n)
    (ks_state_r == KS_RUN && half_r && kr_r == KW'(ROUNDS) && !cfg_wr)
      |=> ks_state_r == KS_IDLE)
    else $error("schedule did not finish after the last round");

  a_kr_range: assert property (@(posedge clk) disable iff (!rst_n)
    ks_state_r == KS_RUN |-> (kr_r >= KW'(1) && kr_r <= KW'(ROUNDS)))
    else $error("schedule round counter out of range");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ks_busy |-> in_stall)
    else $error("block taken while keys are rebuilt");

  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[0] && !adv[1]) |=> v_r[0])
    else $error("first stage lost a block under stall");

endmodule
